// File: rtl/teoq_pkg.sv
// Package for the time-ordered event queue: sizes, entry type, codes.
// No dependencies; imported by every module of the queue.
`default_nettype none

package teoq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int TIME_W   = 31;
  localparam int TAG_W    = 16;
  localparam int PROC_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [TAG_W-1:0]  ev_tag;
    logic [PROC_W-1:0] ev_proc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    MV_HOLD,
    MV_LEFT,
    MV_RIGHT,
    MV_NEW
  } move_e;

  // Outcome of the first-hit search over the row.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
  } pick_t;

endpackage

`default_nettype wire

// File: rtl/time_ordered_event_queue.sv
// Time-ordered event queue top level: FSM, row of teoq_cell slots, teoq_pick search.
// Depends on teoq_pkg, teoq_cell and teoq_pick.
`default_nettype none

// Sorted event queue of QUEUE_DEPTH entries held in a row of cells, earliest
// at cell 0. An item is taken when start is high and busy is low; busy then
// stays high while the cells register their compare flags, the row moves
// and the head is read back, and drops in the cycle in which done_o strobes
// the result for exactly one cycle; no new item is taken until then.
// The result must be captured in the done_o cycle: it is not held back.
// Insert shifts every entry later than the new time one cell towards the
// tail, so equal times leave first in, first out; pop shifts the whole row
// one cell towards the head; find reports the first matching process from
// the head. The head and count fields show the queue after the operation.
// Only cells below the stored count are ever compared or reported, so the
// row needs no clearing after reset.
module time_ordered_event_queue import teoq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op_i,
  input  logic [TIME_W-1:0]   event_time_i,
  input  logic [TAG_W-1:0]    event_tag_i,
  input  logic [PROC_W-1:0]   process_id_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TIME_W-1:0]   out_time_o,
  output logic [TAG_W-1:0]    out_tag_o,
  output logic [PROC_W-1:0]   out_process_o,
  output logic [POS_W-1:0]    position_o,
  output logic                head_valid_o,
  output logic [TIME_W-1:0]   head_time_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXE,
    S_RSP
  } state_e;

  state_e state_q;

  // Latched command.
  logic [OP_W-1:0]   op_q;
  entry_t            new_q;

  logic [CNT_W-1:0]  count_q, count_d;

  // Result registers.
  logic                done_q;
  logic [STATUS_W-1:0] status_q, status_d;
  entry_t              out_q, out_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic                head_valid_q;
  logic [TIME_W-1:0]   head_time_q;

  // Row of cells.
  entry_t           cell_entry [QUEUE_DEPTH];
  move_e            cell_move  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt_vec, match_vec, occ_vec;

  // Shared first-hit search.
  logic [QUEUE_DEPTH-1:0] req_vec, first_vec;
  pick_t                  pick;
  logic [ENTRY_W-1:0]     sel_bits;
  entry_t                 sel_entry;

  logic full, empty;

  assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_e, right_e;

    assign occ_vec[g] = (CNT_W'(g) < count_q);

    if (g == 0) begin : g_first
      assign left_e = new_q;
    end else begin : g_inner_l
      assign left_e = cell_entry[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_entry[g];
    end else begin : g_inner_r
      assign right_e = cell_entry[g+1];
    end

    teoq_cell u_cell (
      .clk_i      (clk_i),
      .move_i     (cell_move[g]),
      .left_i     (left_e),
      .right_i    (right_e),
      .new_i      (new_q),
      .occ_i      (occ_vec[g]),
      .key_time_i (new_q.ev_time),
      .key_proc_i (new_q.ev_proc),
      .entry_o    (cell_entry[g]),
      .gt_o       (gt_vec[g]),
      .match_o    (match_vec[g])
    );
  end

  // Insert looks for the first later entry, find for the first owner.
  assign req_vec = (op_q == OP_INSERT) ? gt_vec : match_vec;

  teoq_pick u_pick (
    .req_i   (req_vec),
    .first_o (first_vec),
    .pick_o  (pick)
  );

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_bits = sel_bits | (cell_entry[i] & {ENTRY_W{first_vec[i]}});
    end
  end

  assign sel_entry = entry_t'(sel_bits);

  // Row moves and result fields, applied only in the execute cycle.
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    out_d    = '0;
    pos_d    = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_move[i] = MV_HOLD;
    end

    if (state_q == S_EXE) begin
      unique case (op_q)
        OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            // Later entries step towards the tail; the gap takes the new item.
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (i > 0 && gt_vec[(i > 0) ? i - 1 : 0]) begin
                cell_move[i] = MV_LEFT;
              end else if (gt_vec[i] || CNT_W'(i) == count_q) begin
                cell_move[i] = MV_NEW;
              end
            end
            pos_d   = pick.hit ? pick.index : IDX_W'(count_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            out_d = cell_entry[0];
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              cell_move[i] = MV_RIGHT;
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_FIND: begin
          if (pick.hit) begin
            out_d = sel_entry;
            pos_d = pick.index;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          // Unused code: leave the queue untouched.
        end
      endcase
    end
  end

  // Sequencer with the command latch and the result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      done_q       <= 1'b0;
      op_q         <= OP_INSERT;
      new_q        <= '0;
      status_q     <= ST_OK;
      out_q        <= '0;
      pos_q        <= '0;
      head_valid_q <= 1'b0;
      head_time_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q          <= op_i;
            new_q.ev_time <= event_time_i;
            new_q.ev_tag  <= event_tag_i;
            new_q.ev_proc <= process_id_i;
            state_q       <= S_CMP;
          end
        end
        S_CMP: begin
          // Cells register their compare flags in this cycle.
          state_q <= S_EXE;
        end
        S_EXE: begin
          count_q  <= count_d;
          status_q <= status_d;
          out_q    <= out_d;
          pos_q    <= pos_d;
          state_q  <= S_RSP;
        end
        S_RSP: begin
          // Head is read back from the row after it has moved.
          head_valid_q <= !empty;
          head_time_q  <= empty ? '0 : cell_entry[0].ev_time;
          done_q       <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_time_o    = out_q.ev_time;
  assign out_tag_o     = out_q.ev_tag;
  assign out_process_o = out_q.ev_proc;
  assign position_o    = POS_W'(pos_q);
  assign head_valid_o  = head_valid_q;
  assign head_time_o   = head_time_q;
  assign entry_count_o = COUNT_W'(count_q);

endmodule

`default_nettype wire

// File: rtl/teoq_cell.sv
// One slot of the sorted row: entry register, neighbour selection, compare flags.
// Depends on teoq_pkg.
`default_nettype none

module teoq_cell import teoq_pkg::*; (
  input  logic              clk_i,
  input  move_e             move_i,
  input  entry_t            left_i,
  input  entry_t            right_i,
  input  entry_t            new_i,
  input  logic              occ_i,
  input  logic [TIME_W-1:0] key_time_i,
  input  logic [PROC_W-1:0] key_proc_i,
  output entry_t            entry_o,
  output logic              gt_o,
  output logic              match_o
);

  entry_t entry_q, entry_d;
  logic   gt_q, match_q;

  always_comb begin
    unique case (move_i)
      MV_HOLD:  entry_d = entry_q;
      MV_LEFT:  entry_d = left_i;
      MV_RIGHT: entry_d = right_i;
      MV_NEW:   entry_d = new_i;
      default:  entry_d = entry_q;
    endcase
  end

  // Flags are taken fresh each cycle against the latched command.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    gt_q    <= occ_i && (entry_q.ev_time > key_time_i);
    match_q <= occ_i && (entry_q.ev_proc == key_proc_i);
  end

  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// File: rtl/teoq_pick.sv
// First-hit finder over the row of cell flags: one-hot of lowest set bit and its index.
// Depends on teoq_pkg.
`default_nettype none

module teoq_pick import teoq_pkg::*; (
  input  logic [QUEUE_DEPTH-1:0] req_i,
  output logic [QUEUE_DEPTH-1:0] first_o,
  output pick_t                  pick_o
);

  logic [IDX_W-1:0] index;

  // Isolate the lowest set bit with one wide add.
  assign first_o = req_i & (~req_i + QUEUE_DEPTH'(1));

  always_comb begin
    index = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      index = index | (IDX_W'(i) & {IDX_W{first_o[i]}});
    end
  end

  assign pick_o.hit   = |req_i;
  assign pick_o.index = index;

endmodule

`default_nettype wire

// File: tb/teoq_checker.sv
// Checker for the time-ordered event queue: watches the command and result ports,
// keeps a shadow copy of the sorted row and compares every result field by field.
// Depends on teoq_pkg.
`default_nettype none

module teoq_checker import teoq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [TIME_W-1:0]   event_time_i,
  input  logic [TAG_W-1:0]    event_tag_i,
  input  logic [PROC_W-1:0]   process_id_i,
  input  logic                done_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [TIME_W-1:0]   out_time_i,
  input  logic [TAG_W-1:0]    out_tag_i,
  input  logic [PROC_W-1:0]   out_process_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                head_valid_i,
  input  logic [TIME_W-1:0]   head_time_i,
  input  logic [COUNT_W-1:0]  entry_count_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   out_time;
    logic [TAG_W-1:0]    out_tag;
    logic [PROC_W-1:0]   out_process;
    logic [POS_W-1:0]    position;
    logic                head_valid;
    logic [TIME_W-1:0]   head_time;
    logic [COUNT_W-1:0]  entry_count;
  } queue_reply_t;

  localparam int RING_DEPTH = 16;

  entry_t       shadow_row [QUEUE_DEPTH];
  int           shadow_count;
  queue_reply_t awaited_ring [RING_DEPTH];
  logic [3:0]   ring_rd;
  logic [3:0]   ring_wr;
  int           ring_fill;
  int           errors;

  // Apply one accepted command to the shadow row and queue up the reply it causes.
  task automatic run_command(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                             input logic [TAG_W-1:0] tag, input logic [PROC_W-1:0] proc);
    queue_reply_t reply;
    int           slot;
    int           k;
    logic         hit;
    reply = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // land after every entry that is not later, so ties stay in arrival order
          slot = shadow_count;
          hit  = 1'b0;
          for (k = 0; k < shadow_count; k++) begin
            if (!hit && shadow_row[k].ev_time > t) begin
              slot = k;
              hit  = 1'b1;
            end
          end
          for (k = shadow_count; k > slot; k--) shadow_row[k] = shadow_row[k-1];
          shadow_row[slot] = '{ev_time: t, ev_tag: tag, ev_proc: proc};
          shadow_count++;
          reply.status   = ST_OK;
          reply.position = POS_W'(slot);
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.status      = ST_OK;
          reply.out_time    = shadow_row[0].ev_time;
          reply.out_tag     = shadow_row[0].ev_tag;
          reply.out_process = shadow_row[0].ev_proc;
          for (k = 1; k < shadow_count; k++) shadow_row[k-1] = shadow_row[k];
          shadow_count--;
        end
      end
      OP_FIND: begin
        reply.status = ST_NOT_FOUND;
        hit          = 1'b0;
        for (k = 0; k < shadow_count; k++) begin
          if (!hit && shadow_row[k].ev_proc == proc) begin
            hit               = 1'b1;
            reply.status      = ST_OK;
            reply.out_time    = shadow_row[k].ev_time;
            reply.out_tag     = shadow_row[k].ev_tag;
            reply.out_process = shadow_row[k].ev_proc;
            reply.position    = POS_W'(k);
          end
        end
      end
      default: begin
        // spare code: nothing moves, only the head and count fields are reported
      end
    endcase
    reply.head_valid  = (shadow_count != 0);
    reply.head_time   = (shadow_count != 0) ? shadow_row[0].ev_time : '0;
    reply.entry_count = COUNT_W'(shadow_count);
    if (ring_fill >= RING_DEPTH) begin
      $error("too many results outstanding");
      errors++;
    end else begin
      awaited_ring[ring_wr] = reply;
      ring_wr               = ring_wr + 4'd1;
      ring_fill++;
    end
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_reply();
    queue_reply_t want;
    if (ring_fill == 0) begin
      $error("result strobed with no command outstanding");
      errors++;
    end else begin
      want    = awaited_ring[ring_rd];
      ring_rd = ring_rd + 4'd1;
      ring_fill--;
      compare_field("status",      32'(want.status),      32'(status_i));
      compare_field("out_time",    32'(want.out_time),    32'(out_time_i));
      compare_field("out_tag",     32'(want.out_tag),     32'(out_tag_i));
      compare_field("out_process", 32'(want.out_process), 32'(out_process_i));
      compare_field("position",    32'(want.position),    32'(position_i));
      compare_field("head_valid",  32'(want.head_valid),  32'(head_valid_i));
      compare_field("head_time",   32'(want.head_time),   32'(head_time_i));
      compare_field("entry_count", 32'(want.entry_count), 32'(entry_count_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      ring_rd      = '0;
      ring_wr      = '0;
      ring_fill    = 0;
      errors       = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (done_i) check_reply();
      if (start_i && !busy_i) begin
        run_command(op_i, event_time_i, event_tag_i, process_id_i);
      end
      mismatches_o  <= errors;
      outstanding_o <= ring_fill;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Top of the event queue testbench: clock, reset, command stimulus and verdict.
// Depends on teoq_pkg, time_ordered_event_queue and teoq_checker.
`default_nettype none

module testbench;
  import teoq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Spare op code: the block must leave the row alone and only report the head and the count.
  localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam int                ITEM_GOAL  = 700;
  // Quiet cycles tolerated before the run is called hung; this is far beyond
  // any gap between items or results in a correct run.
  localparam int                QUIET_LIMIT = 2000;
  // Busy stays high until the cycle in which the result strobes.
  localparam int                SETTLE_CYCLES = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     op_i;
  logic [TIME_W-1:0]   event_time_i;
  logic [TAG_W-1:0]    event_tag_i;
  logic [PROC_W-1:0]   process_id_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [TIME_W-1:0]   out_time_o;
  logic [TAG_W-1:0]    out_tag_o;
  logic [PROC_W-1:0]   out_process_o;
  logic [POS_W-1:0]    position_o;
  logic                head_valid_o;
  logic [TIME_W-1:0]   head_time_o;
  logic [COUNT_W-1:0]  entry_count_o;

  int mismatches;
  int outstanding;
  int quiet_cycles;
  int burst_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  time_ordered_event_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .event_time_i  (event_time_i),
    .event_tag_i   (event_tag_i),
    .process_id_i  (process_id_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_time_o    (out_time_o),
    .out_tag_o     (out_tag_o),
    .out_process_o (out_process_o),
    .position_o    (position_o),
    .head_valid_o  (head_valid_o),
    .head_time_o   (head_time_o),
    .entry_count_o (entry_count_o)
  );

  teoq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op_i),
    .event_time_i  (event_time_i),
    .event_tag_i   (event_tag_i),
    .process_id_i  (process_id_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .out_time_i    (out_time_o),
    .out_tag_i     (out_tag_o),
    .out_process_i (out_process_o),
    .position_i    (position_o),
    .head_valid_i  (head_valid_o),
    .head_time_i   (head_time_o),
    .entry_count_i (entry_count_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Watchdog: reset the count on every accepted item or result, give up when
  // the queue has been silent for far too long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the edge at which the block takes it.
  // Busy is read straight after the edge, so it is the value the edge saw.
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                            input logic [TAG_W-1:0] tag, input logic [PROC_W-1:0] proc);
    start        <= 1'b1;
    op_i         <= op;
    event_time_i <= t;
    event_tag_i  <= tag;
    process_id_i <= proc;
    do @(posedge clk_i); while (busy);
  endtask

  // Count down the current burst; at its end drop start for a random gap.
  // A gap of zero leaves start high, so some bursts run straight into the next.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(0, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Mostly a narrow band so that equal times are common, plus full-range
  // values and values hard against the top of the field.
  function automatic logic [TIME_W-1:0] pick_time();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)      return TIME_W'($urandom_range(0, 31));
    else if (roll < 85) return TIME_W'($urandom());
    else                return TIME_MAX - TIME_W'($urandom_range(0, 3));
  endfunction

  // Few distinct processes, so that find hits more often than it misses.
  function automatic logic [PROC_W-1:0] pick_process();
    if ($urandom_range(0, 99) < 70) return PROC_W'($urandom_range(0, 7));
    else                            return PROC_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int               items_sent;
    int               phase;
    int               span;
    int               insert_pct;
    int               roll;
    int               n;
    logic [OP_W-1:0]  op;

    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = OP_INSERT;
    event_time_i = '0;
    event_tag_i  = '0;
    process_id_i = '0;
    burst_left   = $urandom_range(1, 20);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: operations on an empty queue, field extremes, equal
    // times leaving in arrival order, hit and miss of find, the spare code.
    issue_item(OP_POP,    '0, '0, '0);
    issue_item(OP_FIND,   '0, '0, '0);
    issue_item(OP_SPARE,  TIME_MAX, '1, '1);
    issue_item(OP_INSERT, TIME_MAX, '1, '1);
    issue_item(OP_INSERT, '0, '0, '0);
    issue_item(OP_INSERT, 31'd5, 16'd1, 8'd3);
    issue_item(OP_INSERT, 31'd5, 16'd2, 8'd3);
    issue_item(OP_INSERT, 31'd5, 16'd3, 8'd4);
    issue_item(OP_FIND,   '0, '0, 8'd3);
    issue_item(OP_FIND,   '0, '0, 8'd255);
    issue_item(OP_FIND,   '0, '0, 8'd9);
    issue_item(OP_SPARE,  31'h2AAA_AAAA, 16'h5555, 8'hAA);
    issue_item(OP_INSERT, TIME_MAX, 16'hBEEF, 8'd7);
    repeat (7) issue_item(OP_POP, '0, '0, '0);
    issue_item(OP_INSERT, 31'h2AAA_AAAA, 16'h5555, 8'hAA);
    issue_item(OP_INSERT, 31'h5555_5555, 16'hAAAA, 8'h55);
    issue_item(OP_FIND,   '0, '0, 8'h55);
    issue_item(OP_POP,    '0, '0, '0);
    issue_item(OP_POP,    '0, '0, '0);
    drain_results();

    // Random part in phases: an insert-heavy phase that can fill the queue, a mix,
    // then a pop-heavy phase that can drain it. Spare codes are sent but not counted.
    items_sent = 0;
    phase      = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase % 3)
        0:       begin insert_pct = 85; span = $urandom_range(75, 110); end
        1:       begin insert_pct = 45; span = $urandom_range(30, 90);  end
        default: begin insert_pct = 10; span = $urandom_range(60, 100); end
      endcase
      for (n = 0; n < span; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)           op = OP_INSERT;
        else if (roll < insert_pct + 10) op = OP_FIND;
        else if (roll < insert_pct + 12) op = OP_SPARE;
        else                             op = OP_POP;
        issue_item(op, pick_time(), TAG_W'($urandom_range(0, 65535)), pick_process());
        if (op != OP_SPARE) items_sent++;
        pace_sender();
      end
      // hold off after the insert-heavy phase, letting the queue go idle
      if (phase % 3 == 0) drain_results();
      phase++;
    end

    // Wait out the last results, then a few more cycles for anything stray.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
